FILE: hw/rtl/lookahead_step_sequencer_macros.svh
// Assertion macros for the lookahead step sequencer checker.
// Depends on nothing; included by files that assert.
`ifndef LOOKAHEAD_STEP_SEQUENCER_MACROS_SVH
`define LOOKAHEAD_STEP_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define LSS_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled during reset
`define LSS_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hw/rtl/lss_pkg.sv
// Shared types and constants of the lookahead step sequencer.
// Depends on nothing; used by every RTL module of the block except lss_checker.
package lss_pkg;

  localparam int MAX_STEPS_DEF    = 64;
  localparam int MAX_TRIGGERS_DEF = 16;
  localparam int QUEUE_DEPTH_DEF  = 4;

  localparam logic [2:0] ACT_TICK   = 3'd0;
  localparam logic [2:0] ACT_WRITE  = 3'd1;
  localparam logic [2:0] ACT_COMMIT = 3'd2;
  localparam logic [2:0] ACT_PLAY   = 3'd3;
  localparam logic [2:0] ACT_PAUSE  = 3'd4;
  localparam logic [2:0] ACT_PANIC  = 3'd5;

  typedef struct packed {
    logic [2:0]  action;
    logic [47:0] now_frame;
    logic [5:0]  step_index;
    logic        step_active;
    logic [15:0] step_length;
    logic [6:0]  step_total;
  } lss_cmd_t;

  typedef struct packed {
    logic     valid;
    lss_cmd_t cmd;
  } lss_head_t;

endpackage

FILE: hw/rtl/lss_front.sv
// Front end: accepts input beats, drops those without effect, forms commands.
// Depends on lss_pkg.
module lss_front import lss_pkg::*; #(
  parameter int MAX_STEPS = MAX_STEPS_DEF
) (
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [47:0] in_now_frame,
  input  logic [5:0]  in_step_index,
  input  logic        in_step_active,
  input  logic [15:0] in_step_length,
  input  logic [6:0]  in_step_total,
  input  logic        q_full,
  output logic        q_push,
  output lss_cmd_t    q_cmd
);

  logic known;
  logic keep;

  always_comb begin
    known = (in_action == ACT_TICK) || (in_action == ACT_WRITE) ||
            (in_action == ACT_COMMIT) || (in_action == ACT_PLAY) ||
            (in_action == ACT_PAUSE) || (in_action == ACT_PANIC);
    // drop writes beyond the pattern size
    keep  = known && !((in_action == ACT_WRITE) && (32'(in_step_index) >= MAX_STEPS));
    q_cmd.action      = in_action;
    q_cmd.now_frame   = in_now_frame;
    q_cmd.step_index  = in_step_index;
    q_cmd.step_active = in_step_active;
    q_cmd.step_length = in_step_length;
    q_cmd.step_total  = in_step_total;
  end

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && keep;

endmodule

FILE: hw/rtl/lss_queue.sv
// Command queue between front end and back end.
// Depends on lss_pkg.
module lss_queue import lss_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  lss_cmd_t  push_cmd,
  output logic      full,
  input  logic      pop,
  output lss_head_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);

  lss_cmd_t        entries_r [DEPTH];
  logic [PW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [NW-1:0]   fill_r, fill_nxt;
  logic            do_pop;

  always_comb begin
    do_pop     = pop && (fill_r != '0);
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (push) begin
      wr_ptr_nxt = (32'(wr_ptr_r) == DEPTH - 1) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (32'(rd_ptr_r) == DEPTH - 1) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (!push && do_pop) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_cmd;
    end
  end

  assign full       = (32'(fill_r) == DEPTH);
  assign head.valid = (fill_r != '0);
  assign head.cmd   = entries_r[rd_ptr_r];

endmodule

FILE: hw/rtl/lss_back.sv
// Back end: pattern store, transport state, tick scheduler and result register.
// Depends on lss_pkg; fed by lss_queue.
module lss_back import lss_pkg::*; #(
  parameter int MAX_STEPS    = MAX_STEPS_DEF,
  parameter int MAX_TRIGGERS = MAX_TRIGGERS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  lss_head_t   head,
  output logic        pop,
  input  logic [31:0] frames_per_beat,
  input  logic [19:0] lookahead_frames,
  input  logic        sample_loaded,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_onset_frame,
  output logic        out_panic,
  output logic        out_last
);

  localparam int SW = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int CW = $clog2(MAX_STEPS + 1);
  localparam int AW = $clog2(2 * MAX_STEPS);
  localparam int DEPTH = 2 * MAX_STEPS;
  localparam int VW = $clog2(MAX_TRIGGERS + 1);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_ADD   = 3'd3;
  localparam logic [2:0] ST_FLUSH = 3'd4;
  localparam logic [2:0] ST_PANIC = 3'd5;

  logic [16:0]    mem [DEPTH];
  logic [16:0]    rd_data_r;
  logic           mem_we, mem_re;
  logic [AW-1:0]  mem_waddr, mem_raddr;
  logic [16:0]    mem_wdata;

  logic [2:0]     state_r, state_nxt;
  logic [CW-1:0]  counts_r [2];
  logic [CW-1:0]  counts_nxt [2];
  logic           buf_r, buf_nxt;
  logic [SW-1:0]  cur_r, cur_nxt;
  logic [63:0]    ne_r, ne_nxt;
  logic [63:0]    horizon_r, horizon_nxt;
  logic           playing_r, playing_nxt;
  logic [VW-1:0]  visits_r, visits_nxt;
  logic           held_vld_r, held_vld_nxt;
  logic [47:0]    held_frame_r, held_frame_nxt;
  logic [47:0]    prod_r, prod_nxt;
  logic           out_vld_r, out_vld_nxt;
  logic [47:0]    out_frame_r, out_frame_nxt;
  logic           out_panic_r, out_panic_nxt;
  logic           out_last_r, out_last_nxt;

  logic           slot_free;
  logic [CW-1:0]  count;
  logic [CW-1:0]  commit_count;
  logic [63:0]    now_q;
  logic [64:0]    hsum, esum;
  logic [SW-1:0]  cur_use;
  logic           emit;
  logic           push;
  logic [47:0]    push_frame;
  logic           push_panic, push_last;

  always_comb begin
    state_nxt      = state_r;
    counts_nxt     = counts_r;
    buf_nxt        = buf_r;
    cur_nxt        = cur_r;
    ne_nxt         = ne_r;
    horizon_nxt    = horizon_r;
    playing_nxt    = playing_r;
    visits_nxt     = visits_r;
    held_vld_nxt   = held_vld_r;
    held_frame_nxt = held_frame_r;
    prod_nxt       = prod_r;
    pop            = 1'b0;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    push           = 1'b0;
    push_frame     = held_frame_r;
    push_panic     = 1'b0;
    push_last      = 1'b0;

    slot_free    = !out_vld_r || !out_stall;
    count        = counts_r[buf_r];
    now_q        = {head.cmd.now_frame, 16'b0};
    commit_count = (32'(head.cmd.step_total) > MAX_STEPS) ? CW'(MAX_STEPS)
                                                          : CW'(head.cmd.step_total);
    hsum         = {1'b0, now_q} + {29'b0, lookahead_frames, 16'b0};
    esum         = {1'b0, ne_r} + {25'b0, prod_r[47:8]};
    cur_use      = (32'(cur_r) >= 32'(count)) ? '0 : cur_r;
    emit         = rd_data_r[16] && sample_loaded;
    mem_wdata    = {head.cmd.step_active, head.cmd.step_length};
    mem_waddr    = buf_r ? AW'(head.cmd.step_index)
                         : AW'(MAX_STEPS) + AW'(head.cmd.step_index);
    mem_raddr    = buf_r ? AW'(MAX_STEPS) + AW'(cur_use) : AW'(cur_use);

    case (state_r)
      ST_IDLE: begin
        if (head.valid) begin
          pop = 1'b1;
          case (head.cmd.action)
            ACT_TICK: begin
              if (playing_r && (count != '0)) begin
                ne_nxt      = (ne_r < now_q) ? now_q : ne_r;
                horizon_nxt = hsum[64] ? '1 : hsum[63:0];
                visits_nxt  = '0;
                state_nxt   = ST_CHECK;
              end
            end
            ACT_WRITE: begin
              mem_we = 1'b1;
            end
            ACT_COMMIT: begin
              buf_nxt              = !buf_r;
              counts_nxt[!buf_r]   = commit_count;
              cur_nxt              = '0;
              ne_nxt               = now_q;
            end
            ACT_PLAY: begin
              ne_nxt      = now_q;
              cur_nxt     = '0;
              playing_nxt = 1'b1;
            end
            ACT_PAUSE: begin
              playing_nxt = 1'b0;
            end
            ACT_PANIC: begin
              ne_nxt    = now_q;
              cur_nxt   = '0;
              state_nxt = ST_PANIC;
            end
            default: begin
            end
          endcase
        end
      end
      ST_CHECK: begin
        if ((ne_r <= horizon_r) && (32'(visits_r) < MAX_TRIGGERS)) begin
          cur_nxt   = cur_use;
          mem_re    = 1'b1;
          state_nxt = ST_READ;
        end else begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_READ: begin
        prod_nxt  = 48'(rd_data_r[15:0]) * 48'(frames_per_beat);
        state_nxt = ST_ADD;
      end
      ST_ADD: begin
        // hold until the previous trigger can leave
        if (!(emit && held_vld_r && !slot_free)) begin
          ne_nxt     = esum[64] ? '1 : esum[63:0];
          cur_nxt    = (32'(cur_r) + 1 == 32'(count)) ? '0 : cur_r + 1'b1;
          visits_nxt = visits_r + 1'b1;
          if (emit) begin
            push           = held_vld_r;
            held_vld_nxt   = 1'b1;
            held_frame_nxt = ne_r[63:16];
          end
          state_nxt = ST_CHECK;
        end
      end
      ST_FLUSH: begin
        if (!held_vld_r) begin
          state_nxt = ST_IDLE;
        end else if (slot_free) begin
          push         = 1'b1;
          push_last    = 1'b1;
          held_vld_nxt = 1'b0;
          state_nxt    = ST_IDLE;
        end
      end
      ST_PANIC: begin
        if (slot_free) begin
          push       = 1'b1;
          push_frame = '0;
          push_panic = 1'b1;
          push_last  = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    out_vld_nxt   = out_vld_r;
    out_frame_nxt = out_frame_r;
    out_panic_nxt = out_panic_r;
    out_last_nxt  = out_last_r;
    if (push) begin
      out_vld_nxt   = 1'b1;
      out_frame_nxt = push_frame;
      out_panic_nxt = push_panic;
      out_last_nxt  = push_last;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      counts_r[0] <= '0;
      counts_r[1] <= '0;
      buf_r       <= 1'b0;
      cur_r       <= '0;
      ne_r        <= '0;
      playing_r   <= 1'b0;
      visits_r    <= '0;
      held_vld_r  <= 1'b0;
      out_vld_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      counts_r    <= counts_nxt;
      buf_r       <= buf_nxt;
      cur_r       <= cur_nxt;
      ne_r        <= ne_nxt;
      playing_r   <= playing_nxt;
      visits_r    <= visits_nxt;
      held_vld_r  <= held_vld_nxt;
      out_vld_r   <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    horizon_r    <= horizon_nxt;
    held_frame_r <= held_frame_nxt;
    prod_r       <= prod_nxt;
    out_frame_r  <= out_frame_nxt;
    out_panic_r  <= out_panic_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (mem_re) begin
      rd_data_r <= mem[mem_raddr];
    end
  end

  assign out_valid       = out_vld_r;
  assign out_onset_frame = out_frame_r;
  assign out_panic       = out_panic_r;
  assign out_last        = out_last_r;

endmodule

FILE: hw/rtl/lookahead_step_sequencer.sv
// Lookahead step sequencer: takes one input beat per cycle while its command queue has room;
// the back end handles a write, commit, play or pause, and a tick that finds the transport
// paused or the pattern empty, in its idle state; a panic goes to a panic state, any other
// tick to a check state, then a read and an add state per step visited (at most MAX_TRIGGERS
// visits, each set by one pattern read, one 16x32 multiply and one 64-bit add), then a flush
// state. Result beats leave through an output register; a stalled output holds the tick.
// Configuration is an APB-style port with registers at byte addresses 0, 4 and 8.
// Top level; depends on lss_pkg, lss_front, lss_queue and lss_back.
module lookahead_step_sequencer import lss_pkg::*; #(
  parameter int MAX_STEPS    = MAX_STEPS_DEF,
  parameter int MAX_TRIGGERS = MAX_TRIGGERS_DEF,
  parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_action,
  input  logic [47:0] in_now_frame,
  input  logic [5:0]  in_step_index,
  input  logic        in_step_active,
  input  logic [15:0] in_step_length,
  input  logic [6:0]  in_step_total,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [47:0] out_onset_frame,
  output logic        out_panic,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam logic [1:0] REG_FPB    = 2'd0;
  localparam logic [1:0] REG_LOOK   = 2'd1;
  localparam logic [1:0] REG_SAMPLE = 2'd2;

  logic [31:0] fpb_r;
  logic [19:0] look_r;
  logic        sample_r;
  logic        wr_en;
  logic        q_full, q_push, q_pop;
  lss_cmd_t    q_cmd;
  lss_head_t   q_head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fpb_r    <= 32'd1572864000;
      look_r   <= 20'd9600;
      sample_r <= 1'b0;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_FPB:    fpb_r    <= pwdata;
        REG_LOOK:   look_r   <= pwdata[19:0];
        REG_SAMPLE: sample_r <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FPB:    prdata = fpb_r;
      REG_LOOK:   prdata = {12'b0, look_r};
      REG_SAMPLE: prdata = {31'b0, sample_r};
      default:    prdata = '0;
    endcase
  end

  lss_front #(
    .MAX_STEPS(MAX_STEPS)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_action      (in_action),
    .in_now_frame   (in_now_frame),
    .in_step_index  (in_step_index),
    .in_step_active (in_step_active),
    .in_step_length (in_step_length),
    .in_step_total  (in_step_total),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_cmd          (q_cmd)
  );

  lss_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head)
  );

  lss_back #(
    .MAX_STEPS    (MAX_STEPS),
    .MAX_TRIGGERS (MAX_TRIGGERS)
  ) u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .head             (q_head),
    .pop              (q_pop),
    .frames_per_beat  (fpb_r),
    .lookahead_frames (look_r),
    .sample_loaded    (sample_r),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_onset_frame  (out_onset_frame),
    .out_panic        (out_panic),
    .out_last         (out_last)
  );

endmodule

FILE: hw/rtl/lss_checker.sv
// Port-level checker for the lookahead step sequencer, bound to the top level.
// Depends on lookahead_step_sequencer_macros.svh.
`include "lookahead_step_sequencer_macros.svh"

module lss_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [47:0] out_onset_frame,
  input logic        out_panic,
  input logic        out_last,
  input logic        pready
);

  `LSS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_onset_frame) && $stable(out_panic) && $stable(out_last), "stalled result beat changed")
  `LSS_ASSERT_NOW(a_panic_form, clk, rst_n, out_valid && out_panic, out_last && (out_onset_frame == 48'd0), "panic beat must be last with zero frame")
  `LSS_ASSERT_NOW(a_ready_high, clk, rst_n, 1'b1, pready, "config port not ready")
  `LSS_ASSERT_NOW(a_reset_quiet, clk, rst_n, $past(!rst_n), !out_valid, "result beat right after reset")

endmodule

bind lookahead_step_sequencer lss_checker u_lss_checker (.*);

FILE: sim/lookahead_step_sequencer_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for lookahead_step_sequencer: directed table, then random phases.
// A local copy of sequencer state predicts untyped items' beats; uses lss_pkg only.
module lookahead_step_sequencer_tb import lss_pkg::*;;

  localparam logic [2:0] ACT_SPARE6 = 3'd6;
  localparam logic [2:0] ACT_SPARE7 = 3'd7;

  localparam logic [3:0] REG_FPB       = 4'd0;
  localparam logic [3:0] REG_LOOKAHEAD = 4'd4;
  localparam logic [3:0] REG_SAMPLE    = 4'd8;
  localparam logic [3:0] REG_SPARE     = 4'd12;

  localparam int SETTLE_CYCLES  = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_ITEMS    = 60;
  localparam int PRINT_CAP      = 100;

  typedef struct packed {
    logic [47:0] onset_frame;
    logic        panic;
    logic        last;
  } trigger_t;

  typedef struct packed {
    lss_cmd_t cmd;
    logic     typed;
    logic     has_hit;
    trigger_t hit;
  } plan_row_t;

  localparam trigger_t NO_HIT    = '0;
  localparam trigger_t PANIC_HIT = '{onset_frame: 48'd0, panic: 1'b1, last: 1'b1};

  localparam int DIRECTED_ROWS = 24;
  localparam plan_row_t DIRECTED [DIRECTED_ROWS] = '{
    '{'{ACT_TICK,   48'd0,               6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_SPARE6, 48'hFFFF_FFFF_FFFF,  6'd63, 1'b1, 16'hFFFF, 7'd127}, 1'b1, 1'b0, NO_HIT},
    '{'{ACT_SPARE7, 48'hFFFF_FFFF_FFFF,  6'd63, 1'b1, 16'hFFFF, 7'd127}, 1'b1, 1'b0, NO_HIT},
    '{'{ACT_PANIC,  48'd5,               6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b1, PANIC_HIT},
    '{'{ACT_WRITE,  48'd0,               6'd0,  1'b1, 16'h0100, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_WRITE,  48'd0,               6'd1,  1'b0, 16'h0080, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_WRITE,  48'd0,               6'd2,  1'b1, 16'hFFFF, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_WRITE,  48'd0,               6'd3,  1'b1, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_WRITE,  48'd0,               6'd63, 1'b1, 16'h0040, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_COMMIT, 48'd100,             6'd0,  1'b0, 16'h0000, 7'd4},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_TICK,   48'd100,             6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_PLAY,   48'd100,             6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_TICK,   48'd100,             6'd0,  1'b0, 16'h0000, 7'd0},   1'b0, 1'b0, NO_HIT},
    '{'{ACT_TICK,   48'd24100,           6'd0,  1'b0, 16'h0000, 7'd0},   1'b0, 1'b0, NO_HIT},
    '{'{ACT_TICK,   48'd36100,           6'd0,  1'b0, 16'h0000, 7'd0},   1'b0, 1'b0, NO_HIT},
    '{'{ACT_TICK,   48'hFFFF_FFFF_FFFF,  6'd0,  1'b0, 16'h0000, 7'd0},   1'b0, 1'b0, NO_HIT},
    '{'{ACT_PANIC,  48'd200,             6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b1, PANIC_HIT},
    '{'{ACT_TICK,   48'd200,             6'd0,  1'b0, 16'h0000, 7'd0},   1'b0, 1'b0, NO_HIT},
    '{'{ACT_PAUSE,  48'd0,               6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_TICK,   48'd300,             6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_COMMIT, 48'd0,               6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_PLAY,   48'd0,               6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_TICK,   48'd50,              6'd0,  1'b0, 16'h0000, 7'd0},   1'b1, 1'b0, NO_HIT},
    '{'{ACT_WRITE,  48'd0,               6'd5,  1'b1, 16'h1234, 7'd0},   1'b1, 1'b0, NO_HIT}
  };

  localparam logic [31:0] PHASE_FPB [6] = '{
    32'd1572864000, 32'd0, 32'hFFFF_FFFF, 32'd196608000, 32'd0, 32'd786432000
  };
  localparam logic [19:0] PHASE_LOOKAHEAD [6] = '{
    20'd9600, 20'd0, 20'hFFFFF, 20'd20000, 20'd0, 20'd30000
  };
  localparam logic PHASE_SAMPLE [6] = '{1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1};

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [2:0]  in_action = '0;
  logic [47:0] in_now_frame = '0;
  logic [5:0]  in_step_index = '0;
  logic        in_step_active = 1'b0;
  logic [15:0] in_step_length = '0;
  logic [6:0]  in_step_total = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [47:0] out_onset_frame;
  logic        out_panic;
  logic        out_last;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // predicted sequencer state
  logic [31:0] fpb_q = 32'd1572864000;
  logic [19:0] lookahead_q = 20'd9600;
  logic        sample_q = 1'b0;
  logic        step_on_q [2*MAX_STEPS_DEF];
  logic [15:0] step_len_q [2*MAX_STEPS_DEF];
  logic        slot_written [2*MAX_STEPS_DEF];
  logic [6:0]  step_count_q [2] = '{7'd0, 7'd0};
  logic        bank_q = 1'b0;
  int          cursor_q = 0;
  logic [63:0] event_q = '0;
  logic        running_q = 1'b0;

  trigger_t    fresh_hits [$];
  trigger_t    pending_triggers [$];
  trigger_t    head_trigger;
  int          mismatch_count = 0;
  int          issued_items = 0;
  int          quiet_cycles = 0;
  int          stall_left = 0;
  bit          jitter_on = 1'b1;
  bit          full_fill_done = 1'b0;
  logic [47:0] play_clock = '0;

  lookahead_step_sequencer DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_now_frame    (in_now_frame),
    .in_step_index   (in_step_index),
    .in_step_active  (in_step_active),
    .in_step_length  (in_step_length),
    .in_step_total   (in_step_total),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_onset_frame (out_onset_frame),
    .out_panic       (out_panic),
    .out_last        (out_last),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #5 clk = ~clk;

  task automatic flag_mismatch(input string what);
    if (mismatch_count < PRINT_CAP) $display("[%0t] MISMATCH: %s", $time, what);
    mismatch_count++;
  endtask

  function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] s;
    s = a + b;
    return (s < a) ? '1 : s;
  endfunction

  task automatic advance_sequencer(input lss_cmd_t c);
    logic [63:0] now_q;
    logic [63:0] horizon;
    logic [63:0] adv;
    int          visits;
    int          slot;
    trigger_t    t;
    now_q = {c.now_frame, 16'h0000};
    fresh_hits.delete();
    case (c.action)
      ACT_TICK: begin
        if (running_q && step_count_q[bank_q] != 0) begin
          if (event_q < now_q) event_q = now_q;
          horizon = sat_add(now_q, {28'd0, lookahead_q, 16'h0000});
          visits = 0;
          while (event_q <= horizon && visits < MAX_TRIGGERS_DEF) begin
            if (cursor_q >= step_count_q[bank_q]) cursor_q = 0;
            slot = (bank_q ? MAX_STEPS_DEF : 0) + cursor_q;
            if (step_on_q[slot] && sample_q) begin
              t = '{onset_frame: event_q[63:16], panic: 1'b0, last: 1'b0};
              fresh_hits.push_back(t);
            end
            adv = ({48'd0, step_len_q[slot]} * {32'd0, fpb_q}) >> 8;
            event_q = sat_add(event_q, adv);
            cursor_q = (cursor_q + 1) % step_count_q[bank_q];
            visits++;
          end
          if (fresh_hits.size() > 0) begin
            t = fresh_hits.pop_back();
            t.last = 1'b1;
            fresh_hits.push_back(t);
          end
        end
      end
      ACT_WRITE: begin
        slot = (bank_q ? 0 : MAX_STEPS_DEF) + c.step_index;
        step_on_q[slot] = c.step_active;
        step_len_q[slot] = c.step_length;
        slot_written[slot] = 1'b1;
      end
      ACT_COMMIT: begin
        bank_q = ~bank_q;
        step_count_q[bank_q] = (c.step_total > MAX_STEPS_DEF) ? 7'(MAX_STEPS_DEF) : c.step_total;
        cursor_q = 0;
        event_q = now_q;
      end
      ACT_PLAY: begin
        event_q = now_q;
        cursor_q = 0;
        running_q = 1'b1;
      end
      ACT_PAUSE: running_q = 1'b0;
      ACT_PANIC: begin
        event_q = now_q;
        cursor_q = 0;
        fresh_hits.push_back(PANIC_HIT);
      end
      default: ;
    endcase
  endtask

  function automatic int written_prefix();
    int base;
    base = bank_q ? 0 : MAX_STEPS_DEF;
    for (int i = 0; i < MAX_STEPS_DEF; i++)
      if (!slot_written[base + i]) return i;
    return MAX_STEPS_DEF;
  endfunction

  function automatic lss_cmd_t random_cmd();
    lss_cmd_t c;
    c.action = 3'($urandom_range(0, 7));
    c.now_frame = {16'($urandom), $urandom};
    c.step_index = 6'($urandom);
    c.step_active = 1'($urandom);
    c.step_length = 16'($urandom);
    c.step_total = 7'($urandom);
    return c;
  endfunction

  function automatic logic [15:0] pick_length();
    return ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 256));
  endfunction

  task automatic send_item(input lss_cmd_t c, input logic typed = 1'b0,
                           input logic has_hit = 1'b0, input trigger_t hit = '0);
    if (jitter_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_action      <= c.action;
    in_now_frame   <= c.now_frame;
    in_step_index  <= c.step_index;
    in_step_active <= c.step_active;
    in_step_length <= c.step_length;
    in_step_total  <= c.step_total;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_sequencer(c);
    if (typed) begin
      if (has_hit) pending_triggers.push_back(hit);
    end else begin
      foreach (fresh_hits[i]) pending_triggers.push_back(fresh_hits[i]);
    end
    if (c.action <= ACT_PANIC) issued_items++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (pending_triggers.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [3:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (addr)
      REG_FPB:       fpb_q = data;
      REG_LOOKAHEAD: lookahead_q = data[19:0];
      REG_SAMPLE:    sample_q = data[0];
      default: ;
    endcase
  endtask

  task automatic apply_settings(input logic [31:0] fpb, input logic [19:0] la,
                                input logic sample, input bit poke_spare);
    write_reg(REG_FPB, fpb);
    write_reg(REG_LOOKAHEAD, {12'($urandom), la});
    write_reg(REG_SAMPLE, {31'($urandom), sample});
    if (poke_spare) write_reg(REG_SPARE, $urandom);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic run_random_phase(input int budget, input bit calm);
    int         start;
    int         n;
    int         k;
    int         reps;
    logic [6:0] total;
    lss_cmd_t   c;
    start = issued_items;
    while (issued_items - start < budget) begin
      jitter_on = !calm && ($urandom_range(0, 3) != 0);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          n = (!full_fill_done || $urandom_range(0, 14) == 0) ? MAX_STEPS_DEF
                                                             : $urandom_range(1, 8);
          if (n == MAX_STEPS_DEF) full_fill_done = 1'b1;
          for (int i = 0; i < n; i++) begin
            c = random_cmd();
            c.action = ACT_WRITE;
            c.step_index = 6'(i);
            c.step_active = ($urandom_range(0, 3) != 0);
            c.step_length = pick_length();
            send_item(c);
          end
          k = written_prefix();
          if (k == MAX_STEPS_DEF && $urandom_range(0, 1) == 1)
            total = 7'($urandom_range(MAX_STEPS_DEF, 127));
          else if ($urandom_range(0, 3) == 0)
            total = 7'($urandom_range(0, k));
          else
            total = 7'(n);
          c = random_cmd();
          c.action = ACT_COMMIT;
          c.now_frame = play_clock;
          c.step_total = total;
          send_item(c);
          if ($urandom_range(0, 3) != 0) begin
            c = random_cmd();
            c.action = ACT_PLAY;
            c.now_frame = play_clock;
            send_item(c);
          end
          reps = $urandom_range(2, 10);
          repeat (reps) begin
            c = random_cmd();
            c.now_frame = play_clock;
            case ($urandom_range(0, 19))
              0, 1:    c.action = ACT_PANIC;
              2:       c.action = ACT_PAUSE;
              3:       c.action = ACT_PLAY;
              default: c.action = ACT_TICK;
            endcase
            send_item(c);
            play_clock = play_clock + 48'($urandom_range(0, 2 * lookahead_q + 4000));
          end
        end
        6, 7: begin
          c = random_cmd();
          if (c.action == ACT_COMMIT) c.action = ACT_TICK;
          send_item(c);
        end
        8: begin
          play_clock = {16'($urandom), $urandom};
          c = random_cmd();
          c.action = ACT_TICK;
          c.now_frame = play_clock;
          send_item(c);
        end
        default: begin
          c = random_cmd();
          c.action = ACT_PAUSE;
          send_item(c);
          c = random_cmd();
          c.action = ACT_TICK;
          c.now_frame = play_clock;
          send_item(c);
          c = random_cmd();
          c.action = ACT_PLAY;
          c.now_frame = play_clock;
          send_item(c);
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (jitter_on && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 3);
      out_stall  <= 1'b1;
    end else begin
      out_stall  <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_triggers.size() == 0) begin
        flag_mismatch($sformatf("unexpected beat onset_frame=%0d panic=%0b last=%0b",
                                out_onset_frame, out_panic, out_last));
      end else begin
        head_trigger = pending_triggers.pop_front();
        if (out_onset_frame !== head_trigger.onset_frame)
          flag_mismatch($sformatf("onset_frame got %0d want %0d",
                                  out_onset_frame, head_trigger.onset_frame));
        if (out_panic !== head_trigger.panic)
          flag_mismatch($sformatf("panic got %0b want %0b", out_panic, head_trigger.panic));
        if (out_last !== head_trigger.last)
          flag_mismatch($sformatf("last got %0b want %0b", out_last, head_trigger.last));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  initial begin
    logic [31:0] fpb_pick;
    logic [19:0] la_pick;
    for (int i = 0; i < 2 * MAX_STEPS_DEF; i++) begin
      step_on_q[i] = 1'b0;
      step_len_q[i] = '0;
      slot_written[i] = 1'b0;
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    apply_settings(32'd1572864000, 20'd9600, 1'b1, 1'b0);
    for (int r = 0; r < DIRECTED_ROWS; r++)
      send_item(DIRECTED[r].cmd, DIRECTED[r].typed, DIRECTED[r].has_hit, DIRECTED[r].hit);
    drain();

    for (int p = 0; p < 6; p++) begin
      fpb_pick = PHASE_FPB[p];
      la_pick = PHASE_LOOKAHEAD[p];
      if (p == 4) begin
        fpb_pick = $urandom_range(32'h0001_0000, 32'd3145728000);
        la_pick = 20'($urandom_range(0, 60000));
      end
      jitter_on = 1'b0;
      apply_settings(fpb_pick, la_pick, PHASE_SAMPLE[p], p == 4);
      run_random_phase(PHASE_ITEMS, p == 5);
      drain();
    end

    if (mismatch_count == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
